// ===== rtl/segment_allocator_fit_policy_core_assert.svh =====
// assertion macros for the allocator top level
`ifndef SEGMENT_ALLOCATOR_FIT_POLICY_CORE_ASSERT_SVH
`define SEGMENT_ALLOCATOR_FIT_POLICY_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define SAC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define SAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/sac_pkg.sv =====
// package: sizes, codes and table entry type of the segment allocator
package sac_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
   localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);
   localparam int ADDR_BITS    = 16;
   localparam int LEN_BITS     = 16;

   localparam logic [1:0] FIRST_FIT = 2'd0;
   localparam logic [1:0] BEST_FIT  = 2'd1;
   localparam logic [1:0] WORST_FIT = 2'd2;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_INIT  = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOFIT   = 3'd1;
   localparam logic [2:0] ST_BADFREE = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_ZERO    = 3'd4;

   localparam logic CSR_FIT_STRATEGY = 1'b0;
   localparam logic CSR_POOL_UNITS   = 1'b1;

   typedef struct packed {
      logic                 busy;
      logic [ADDR_BITS-1:0] base;
      logic [LEN_BITS-1:0]  len;
   } seg_entry_type;

   localparam int ENTRY_BITS = $bits(seg_entry_type);

   typedef struct packed {
      logic                 vld;
      logic                 is_free;
      logic [1:0]           strategy;
      logic [LEN_BITS-1:0]  size;
      logic [ADDR_BITS-1:0] addr;
      logic [IDX_BITS-1:0]  idx;
      seg_entry_type        entry;
   } sac_eval_type;

   typedef struct packed {
      logic                found;
      logic [IDX_BITS-1:0] idx;
      seg_entry_type       entry;
   } sac_pick_type;

endpackage

// ===== rtl/sac_if.sv =====
// request and response channel interfaces
interface sac_req_if import sac_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           cmd;
   logic [LEN_BITS-1:0]  req_size;
   logic [ADDR_BITS-1:0] free_addr;
   modport source (output valid, cmd, req_size, free_addr, input ready);
   modport sink (input valid, cmd, req_size, free_addr, output ready);
endinterface

interface sac_rsp_if import sac_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [2:0]           status;
   logic [ADDR_BITS-1:0] alloc_addr;
   modport source (output valid, status, alloc_addr, input ready);
   modport sink (input valid, status, alloc_addr, output ready);
endinterface

// ===== rtl/sac_ram.sv =====
// generic single-write, single-read ram with registered read data
module sac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/sac_pick.sv =====
// candidate tracker: keeps the chosen segment while the table is scanned
module sac_pick import sac_pkg::*; (
   input  logic         clock,
   input  logic         clear,
   input  sac_eval_type ev,
   output sac_pick_type pick
);
   logic          found_ff, found_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   seg_entry_type entry_ff, entry_in;
   logic          fits;
   logic          better;

   always_comb begin
      if (ev.is_free) begin
         fits = ev.entry.busy && (ev.entry.base == ev.addr);
      end else begin
         fits = !ev.entry.busy && (ev.entry.len >= ev.size);
      end
      // only best and worst fit replace an earlier candidate
      better = !found_ff ||
               (!ev.is_free && ev.strategy == BEST_FIT && ev.entry.len < entry_ff.len) ||
               (!ev.is_free && ev.strategy == WORST_FIT && ev.entry.len > entry_ff.len);
      found_in = found_ff;
      idx_in   = idx_ff;
      entry_in = entry_ff;
      if (clear) begin
         found_in = 1'b0;
      end else if (ev.vld && fits && better) begin
         found_in = 1'b1;
         idx_in   = ev.idx;
         entry_in = ev.entry;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      idx_ff   <= idx_in;
      entry_ff <= entry_in;
   end

   assign pick = '{found: found_ff, idx: idx_ff, entry: entry_ff};
endmodule

// ===== rtl/segment_allocator_fit_policy_core.sv =====
// top level: segment table allocator with first, best and worst fit
//
// The segment table lives in one RAM of MAX_SEGMENTS entries, one read and
// one write a cycle. Every allocate or free scans the live entries once,
// but for a zero-size allocate or one under a reserved strategy. A split
// allocate then moves the entries above the chosen one up by one and
// writes two entries; a free runs a compaction pass that merges free
// neighbors. After reset the block writes the initial pool entry in its
// boot state before it takes a word. One item is worked on at a time; the
// response sits in an output register until taken.
module segment_allocator_fit_policy_core import sac_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   sac_req_if.sink             req_chan,
   sac_rsp_if.source           rsp_chan,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [LEN_BITS-1:0] csr_wr_data
);
`include "segment_allocator_fit_policy_core_assert.svh"

   typedef enum logic [9:0] {
      S_BOOT   = 10'b0000000001,
      S_IDLE   = 10'b0000000010,
      S_SCAN   = 10'b0000000100,
      S_DECIDE = 10'b0000001000,
      S_SHIFT  = 10'b0000010000,
      S_SPLIT  = 10'b0000100000,
      S_MARK   = 10'b0001000000,
      S_MERGE  = 10'b0010000000,
      S_MLAST  = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]           strategy_ff;
   logic [LEN_BITS-1:0]  pool_ff;
   logic [1:0]           cmd_ff, cmd_in;
   logic [LEN_BITS-1:0]  size_ff, size_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [CNT_BITS-1:0]  total_ff, total_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]  wcnt_ff, wcnt_in;
   logic                 split_ff, split_in;
   logic                 have_ff, have_in;
   seg_entry_type        pend_ff, pend_in;
   logic [2:0]           res_status_ff, res_status_in;
   logic [ADDR_BITS-1:0] res_addr_ff, res_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [ADDR_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IDX_BITS-1:0]  rd_idx_ff;

   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_addr;
   seg_entry_type        wr_data;
   logic [IDX_BITS-1:0]  rd_addr;
   logic [ENTRY_BITS-1:0] rd_raw;
   seg_entry_type        rd_entry;
   seg_entry_type        mrg_entry;
   logic                 pick_clear;
   sac_eval_type         ev;
   sac_pick_type         pick;
   logic                 req_fire;
   logic [CNT_BITS-1:0]  pick_next;

   sac_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   sac_pick u_pick (
      .clock (clock),
      .clear (pick_clear),
      .ev    (ev),
      .pick  (pick)
   );

   assign rd_entry  = seg_entry_type'(rd_raw);
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign pick_next = CNT_BITS'(pick.idx) + CNT_BITS'(1);

   always_comb begin
      mrg_entry = rd_entry;
      if (rd_idx_ff == pick.idx) begin
         mrg_entry.busy = 1'b0;
      end
      ev = '{vld: rd_vld_ff && state_ff == S_SCAN, is_free: cmd_ff == CMD_FREE,
             strategy: strategy_ff, size: size_ff, addr: addr_ff, idx: rd_idx_ff,
             entry: rd_entry};
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      total_in      = total_ff;
      cnt_in        = cnt_ff;
      wcnt_in       = wcnt_ff;
      split_in      = split_ff;
      have_in       = have_ff;
      pend_in       = pend_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rd_vld_in     = 1'b0;
      rd_addr       = cnt_ff[IDX_BITS-1:0];
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '{busy: 1'b0, base: '0, len: pool_ff};
      pick_clear    = 1'b0;

      case (state_ff)
         S_BOOT: begin
            wr_en    = 1'b1;
            total_in = CNT_BITS'(1);
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd_in        = req_chan.cmd;
               size_in       = req_chan.req_size;
               addr_in       = req_chan.free_addr;
               cnt_in        = '0;
               pick_clear    = 1'b1;
               res_status_in = ST_OK;
               res_addr_in   = '0;
               state_in      = S_SCAN;
               case (req_chan.cmd)
                  CMD_ALLOC: begin
                     if (req_chan.req_size == '0) begin
                        res_status_in = ST_ZERO;
                        state_in      = S_DONE;
                     end else if (strategy_ff != FIRST_FIT && strategy_ff != BEST_FIT &&
                                  strategy_ff != WORST_FIT) begin
                        res_status_in = ST_NOFIT;
                        state_in      = S_DONE;
                     end
                  end
                  CMD_FREE: begin
                  end
                  CMD_INIT: begin
                     wr_en    = 1'b1;
                     total_in = CNT_BITS'(1);
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (cnt_ff < total_ff) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + CNT_BITS'(1);
            end else if (!rd_vld_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (cmd_ff == CMD_FREE) begin
               if (!pick.found) begin
                  res_status_in = ST_BADFREE;
                  state_in      = S_DONE;
               end else begin
                  cnt_in   = '0;
                  wcnt_in  = '0;
                  have_in  = 1'b0;
                  state_in = S_MERGE;
               end
            end else if (!pick.found) begin
               res_status_in = ST_NOFIT;
               state_in      = S_DONE;
            end else if (pick.entry.len > size_ff) begin
               if (total_ff >= CNT_BITS'(MAX_SEGMENTS)) begin
                  res_status_in = ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  split_in = 1'b1;
                  cnt_in   = total_ff;
                  state_in = S_SHIFT;
               end
            end else begin
               split_in = 1'b0;
               state_in = S_MARK;
            end
         end
         S_SHIFT: begin
            // read k-1, write it to k in the next cycle, walking downward
            rd_addr = IDX_BITS'(cnt_ff - CNT_BITS'(1));
            if (cnt_ff > pick_next) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff - CNT_BITS'(1);
            end else if (!rd_vld_ff) begin
               state_in = S_SPLIT;
            end
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff + IDX_BITS'(1);
               wr_data = rd_entry;
            end
         end
         S_SPLIT: begin
            wr_en    = 1'b1;
            wr_addr  = pick_next[IDX_BITS-1:0];
            wr_data  = '{busy: 1'b0, base: pick.entry.base + ADDR_BITS'(size_ff),
                         len: pick.entry.len - size_ff};
            state_in = S_MARK;
         end
         S_MARK: begin
            wr_en       = 1'b1;
            wr_addr     = pick.idx;
            wr_data     = '{busy: 1'b1, base: pick.entry.base, len: size_ff};
            total_in    = total_ff + CNT_BITS'(split_ff);
            res_addr_in = pick.entry.base;
            state_in    = S_DONE;
         end
         S_MERGE: begin
            // compaction: writes trail reads, so unread entries stay intact
            if (cnt_ff < total_ff) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + CNT_BITS'(1);
            end else if (!rd_vld_ff) begin
               state_in = S_MLAST;
            end
            if (rd_vld_ff) begin
               if (!have_ff) begin
                  have_in = 1'b1;
                  pend_in = mrg_entry;
               end else if (!pend_ff.busy && !mrg_entry.busy) begin
                  pend_in.len = pend_ff.len + mrg_entry.len;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = wcnt_ff[IDX_BITS-1:0];
                  wr_data = pend_ff;
                  wcnt_in = wcnt_ff + CNT_BITS'(1);
                  pend_in = mrg_entry;
               end
            end
         end
         S_MLAST: begin
            wr_en    = 1'b1;
            wr_addr  = wcnt_ff[IDX_BITS-1:0];
            wr_data  = pend_ff;
            total_in = wcnt_ff + CNT_BITS'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = (res_status_ff == ST_OK) ? res_addr_ff : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BOOT;
         strategy_ff  <= FIRST_FIT;
         pool_ff      <= LEN_BITS'(1024);
         total_ff     <= CNT_BITS'(1);
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FIT_STRATEGY: strategy_ff <= csr_wr_data[1:0];
               CSR_POOL_UNITS:   pool_ff     <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      cnt_ff        <= cnt_in;
      wcnt_ff       <= wcnt_in;
      split_ff      <= split_in;
      have_ff       <= have_in;
      pend_ff       <= pend_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rd_idx_ff     <= rd_addr;
   end

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.alloc_addr = rsp_addr_ff;

   `SAC_ASSERT_IMPL(a_total_range, clock, reset, 1'b1,
                    total_ff != '0 && total_ff <= CNT_BITS'(MAX_SEGMENTS))
   `SAC_ASSERT_IMPL(a_idle_no_read, clock, reset, state_ff == S_IDLE, !rd_vld_ff)
   `SAC_ASSERT_IMPL(a_fail_addr_zero, clock, reset,
                    rsp_valid_ff && rsp_status_ff != ST_OK, rsp_addr_ff == '0)
   `SAC_ASSERT_NEXT(a_merge_trails, clock, reset, state_ff == S_MERGE,
                    wcnt_ff <= cnt_ff)
endmodule

// ===== verif/segment_allocator_fit_policy_core_tb.sv =====
// testbench for the segment allocator: directed table, random ops, scoreboard
module segment_allocator_fit_policy_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sac_pkg::*;

   typedef struct {
      logic [1:0]  cmd;
      logic [15:0] size;
      logic [15:0] addr;
      bit          fixed;
      logic [2:0]  x_status;
      logic [15:0] x_addr;
   } stim_row_type;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] addr;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_index = 1'b0;
   logic [LEN_BITS-1:0] csr_wr_data = '0;

   sac_req_if req_chan ();
   sac_rsp_if rsp_chan ();

   segment_allocator_fit_policy_core i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [1:0]  pol_fit;
   logic [15:0] pol_pool;
   logic [15:0] tbl_base [MAX_SEGMENTS];
   logic [15:0] tbl_len [MAX_SEGMENTS];
   bit          tbl_busy [MAX_SEGMENTS];
   int          tbl_count;
   logic [15:0] live_addrs [$];

   grant_type pending_grants [$];
   int     err_count = 0;
   int     seen_words = 0;
   int     idle_cycles = 0;
   int     n_ok = 0, n_nofit = 0, n_bad = 0, n_full = 0, n_zero = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   function automatic void table_rebuild();
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
         tbl_base[i] = '0; tbl_len[i] = '0; tbl_busy[i] = 1'b0;
      end
      tbl_len[0] = pol_pool;
      tbl_count = 1;
      live_addrs.delete();
   endfunction

   function automatic void table_merge();
      int i;
      i = 0;
      while (i + 1 < tbl_count) begin
         if (!tbl_busy[i] && !tbl_busy[i+1]) begin
            tbl_len[i] += tbl_len[i+1];
            for (int k = i + 1; k + 1 < tbl_count; k++) begin
               tbl_base[k] = tbl_base[k+1]; tbl_len[k] = tbl_len[k+1];
               tbl_busy[k] = tbl_busy[k+1];
            end
            tbl_count--;
         end else begin
            i++;
         end
      end
   endfunction

   function automatic grant_type allocator_step(logic [1:0] cmd, logic [15:0] size,
                                                logic [15:0] where);
      grant_type g;
      bit found;
      int pick;
      g.status = ST_OK;
      g.addr = '0;
      found = 0;
      pick = 0;
      if (cmd == CMD_ALLOC) begin
         if (size == 16'd0) g.status = ST_ZERO;
         else if (pol_fit > WORST_FIT) g.status = ST_NOFIT;
         else begin
            for (int i = 0; i < tbl_count; i++) begin
               if (tbl_busy[i] || tbl_len[i] < size) continue;
               if (!found) begin
                  found = 1; pick = i;
                  if (pol_fit == FIRST_FIT) break;
               end else if (pol_fit == BEST_FIT && tbl_len[i] < tbl_len[pick]) pick = i;
               else if (pol_fit == WORST_FIT && tbl_len[i] > tbl_len[pick]) pick = i;
            end
            if (!found) g.status = ST_NOFIT;
            else if (tbl_len[pick] > size && tbl_count >= MAX_SEGMENTS) g.status = ST_FULL;
            else begin
               if (tbl_len[pick] > size) begin
                  for (int k = tbl_count; k > pick + 1; k--) begin
                     tbl_base[k] = tbl_base[k-1]; tbl_len[k] = tbl_len[k-1];
                     tbl_busy[k] = tbl_busy[k-1];
                  end
                  tbl_base[pick+1] = tbl_base[pick] + size;
                  tbl_len[pick+1] = tbl_len[pick] - size;
                  tbl_busy[pick+1] = 1'b0;
                  tbl_count++;
               end
               tbl_len[pick] = size;
               tbl_busy[pick] = 1'b1;
               g.addr = tbl_base[pick];
               live_addrs.push_back(g.addr);
            end
         end
      end else if (cmd == CMD_FREE) begin
         g.status = ST_BADFREE;
         for (int i = 0; i < tbl_count; i++) begin
            if (tbl_busy[i] && tbl_base[i] == where) begin
               tbl_busy[i] = 1'b0;
               table_merge();
               g.status = ST_OK;
               foreach (live_addrs[j]) if (live_addrs[j] == where) begin
                  live_addrs.delete(j);
                  break;
               end
               break;
            end
         end
      end else if (cmd == CMD_INIT) begin
         table_rebuild();
      end
      return g;
   endfunction

   // receiver: own stall pattern, checks on the rising edge
   always @(negedge clock) begin
      if ((seen_words / 60) % 3 == 2) rsp_chan.ready <= 1'b1;
      else rsp_chan.ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles > 20000) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("segment_allocator_fit_policy_core_tb: FAIL");
            $finish;
         end
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen_words++;
         if (pending_grants.size() == 0) begin
            report("unexpected word", 32'(rsp_chan.status), 32'd0);
         end else begin
            grant_type w;
            w = pending_grants.pop_front();
            if (rsp_chan.status !== w.status)
               report("status", 32'(rsp_chan.status), 32'(w.status));
            if (rsp_chan.alloc_addr !== w.addr)
               report("alloc_addr", 32'(rsp_chan.alloc_addr), 32'(w.addr));
            case (w.status)
               ST_OK:    n_ok++;
               ST_NOFIT: n_nofit++;
               ST_BADFREE: n_bad++;
               ST_FULL:  n_full++;
               default:  n_zero++;
            endcase
         end
      end
   end

   task automatic send_word(input logic [1:0] cmd, input logic [15:0] size,
                            input logic [15:0] where, input bit fixed,
                            input logic [2:0] x_status, input logic [15:0] x_addr);
      grant_type g;
      req_chan.valid <= 1'b1;
      req_chan.cmd <= cmd;
      req_chan.req_size <= size;
      req_chan.free_addr <= where;
      do @(posedge clock); while (!req_chan.ready);
      g = allocator_step(cmd, size, where);
      if (fixed && (g.status !== x_status || g.addr !== x_addr))
         report("directed row", 32'({g.status, g.addr}), 32'({x_status, x_addr}));
      pending_grants.push_back(g);
      @(negedge clock);
   endtask

   task automatic send_gap();
      req_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_grants.size() != 0) @(negedge clock);
      repeat (2 * MAX_SEGMENTS + 20) @(negedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [15:0] val);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_FIT_STRATEGY) pol_fit = val[1:0];
      else pol_pool = val;
   endtask

   function automatic logic [15:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return 16'($urandom_range(0, 65535));
         1:       return 16'd0;
         2, 3:    return 16'($urandom_range(1, 4));
         default: return 16'($urandom_range(1, 80));
      endcase
   endfunction

   // directed: after reset with first fit on a 1024-unit pool
   stim_row_type steps [] = '{
      '{CMD_ALLOC, 16'd0,     16'd0,   1, ST_ZERO,    16'd0},
      '{CMD_ALLOC, 16'd100,   16'd0,   1, ST_OK,      16'd0},
      '{CMD_ALLOC, 16'd65535, 16'd0,   1, ST_NOFIT,   16'd0},
      '{CMD_ALLOC, 16'd200,   16'd0,   1, ST_OK,      16'd100},
      '{CMD_FREE,  16'd0,     16'd50,  1, ST_BADFREE, 16'd0},
      '{CMD_FREE,  16'hffff,  16'd0,   1, ST_OK,      16'd0},
      '{CMD_FREE,  16'd0,     16'd0,   1, ST_BADFREE, 16'd0},
      '{CMD_ALLOC, 16'd50,    16'hffff,0, ST_OK,      16'd0},
      '{CMD_ALLOC, 16'd724,   16'd0,   0, ST_OK,      16'd0},
      '{2'd3,      16'hffff,  16'hffff,1, ST_OK,      16'd0},
      '{CMD_FREE,  16'd0,     16'd100, 0, ST_OK,      16'd0},
      '{CMD_FREE,  16'd0,     16'hffff,1, ST_BADFREE, 16'd0},
      '{CMD_INIT,  16'hffff,  16'hffff,1, ST_OK,      16'd0},
      '{CMD_ALLOC, 16'd1024,  16'd0,   1, ST_OK,      16'd0},
      '{CMD_ALLOC, 16'd1,     16'd0,   1, ST_NOFIT,   16'd0},
      '{CMD_FREE,  16'd0,     16'd0,   1, ST_OK,      16'd0}
   };

   initial begin
      int fills;
      logic [15:0] pools [4];
      pools[0] = 16'd1;
      pools[1] = 16'd400;
      pools[2] = 16'd1024;
      pools[3] = 16'd65535;
      req_chan.valid = 1'b0;
      req_chan.cmd = CMD_ALLOC;
      req_chan.req_size = '0;
      req_chan.free_addr = '0;
      pol_fit = FIRST_FIT;
      pol_pool = 16'd1024;
      table_rebuild();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (steps[r])
         send_word(steps[r].cmd, steps[r].size, steps[r].addr, steps[r].fixed,
                   steps[r].x_status, steps[r].x_addr);
      drain();

      // table full: 1-unit allocations on a large pool until a split is refused
      csr_write(CSR_POOL_UNITS, 16'd65535);
      send_word(CMD_INIT, 16'd0, 16'd0, 0, ST_OK, 16'd0);
      for (int i = 0; i < MAX_SEGMENTS; i++)
         send_word(CMD_ALLOC, 16'd1, 16'd0, 0, ST_OK, 16'd0);
      send_word(CMD_ALLOC, 16'(65535 - (MAX_SEGMENTS - 1)), 16'd0, 0, ST_OK, 16'd0);
      drain();

      // zero pool and reserved strategy
      csr_write(CSR_POOL_UNITS, 16'd0);
      send_word(CMD_INIT, 16'd0, 16'd0, 1, ST_OK, 16'd0);
      send_word(CMD_ALLOC, 16'd1, 16'd0, 1, ST_NOFIT, 16'd0);
      drain();
      csr_write(CSR_POOL_UNITS, 16'd1);
      csr_write(CSR_FIT_STRATEGY, 16'd3);
      send_word(CMD_INIT, 16'd0, 16'd0, 0, ST_OK, 16'd0);
      send_word(CMD_ALLOC, 16'd1, 16'd0, 1, ST_NOFIT, 16'd0);
      drain();

      // random phases over each policy and several pool sizes
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(CSR_FIT_STRATEGY, 16'((ph == 5) ? 3 : ph % 3));
         csr_write(CSR_POOL_UNITS, pools[$urandom_range(0, 3)]);
         send_word(CMD_INIT, 16'd0, 16'd0, 0, ST_OK, 16'd0);
         fills = 0;
         while (fills < 60) begin
            int burst;
            burst = (ph == 2) ? 60 : $urandom_range(1, 10);
            for (int b = 0; b < burst && fills < 60; b++) begin
               int k;
               logic [15:0] a;
               k = $urandom_range(0, 99);
               if (k < 50)
                  send_word(CMD_ALLOC, pick_size(), 16'($urandom), 0, ST_OK, 16'd0);
               else if (k < 85 && live_addrs.size() != 0) begin
                  a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
                  send_word(CMD_FREE, 16'($urandom), a, 0, ST_OK, 16'd0);
               end else if (k < 92)
                  send_word(CMD_FREE, 16'($urandom), 16'($urandom), 0, ST_OK, 16'd0);
               else if (k < 95)
                  send_word(CMD_INIT, 16'($urandom), 16'($urandom), 0, ST_OK, 16'd0);
               else if (k < 97)
                  send_word(2'd3, 16'($urandom), 16'($urandom), 0, ST_OK, 16'd0);
               else
                  send_word(CMD_ALLOC, pick_size(), 16'($urandom), 0, ST_OK, 16'd0);
               fills++;
            end
            if (ph != 2) send_gap();
         end
         drain();
      end

      $display("covered %0d words: ok %0d, no fit %0d, bad free %0d, full %0d, zero %0d",
               seen_words, n_ok, n_nofit, n_bad, n_full, n_zero);
      $display("policies first/best/worst/reserved, pools 0 to 65535, full-table split");
      if (err_count == 0)
         $display("segment_allocator_fit_policy_core_tb: PASS");
      else
         $display("segment_allocator_fit_policy_core_tb: FAIL");
      $finish;
   end
endmodule

// ===== segment_allocator_fit_policy_core.f =====
+incdir+rtl
rtl/sac_pkg.sv
rtl/sac_if.sv
rtl/sac_ram.sv
rtl/sac_pick.sv
rtl/segment_allocator_fit_policy_core.sv
verif/segment_allocator_fit_policy_core_tb.sv
